@@ rtl/core/pwmdec_pkg.sv @@
// Shared types and constants for the pulse-width duty-cycle bit decoder.
// Has no dependencies. It is used by pwmdec_eval and pwm_duty_bit_decoder_top.
`default_nettype none

package pwmdec_pkg;

    // Width of the configuration registers and of the reported code word.
    localparam int CFG_WIDTH  = 16;
    localparam int CODE_WIDTH = 16;

    // Ratio bounds. The longer time must lie strictly between these multiples of the shorter one.
    localparam int RATIO_LOW  = 3;
    localparam int RATIO_HIGH = 5;

    // Reset values of the configuration registers.
    localparam logic [CFG_WIDTH-1:0] PERIOD_MIN_RESET = 16'd500;
    localparam logic [CFG_WIDTH-1:0] PERIOD_MAX_RESET = 16'd1500;
    localparam logic [CFG_WIDTH-1:0] UNLOCK_KEY_RESET = 16'h68af;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_PERIOD_MIN = 2'd0,
        REG_PERIOD_MAX = 2'd1,
        REG_UNLOCK_KEY = 2'd2
    } cfg_index_t;

    // Status flags reported with every result item.
    typedef struct packed {
        logic was_rising;
        logic bit_valid;
        logic bit_value;
        logic pulse_error;
        logic key_match;
    } pwmdec_flags_t;

endpackage : pwmdec_pkg

`default_nettype wire

@@ rtl/core/pwmdec_eval.sv @@
// Combinational evaluation of one edge interval against the decoder state.
// Depends on pwmdec_pkg for the ratio constants and the flag struct.
`default_nettype none

module pwmdec_eval
    import pwmdec_pkg::*;
#(
    parameter int INTERVAL_WIDTH = 16,
    parameter int KEY_WIDTH      = 16
) (
    input  wire logic [INTERVAL_WIDTH-1:0] cur_interval,
    input  wire logic                      edge_phase,
    input  wire logic [INTERVAL_WIDTH-1:0] prior_interval,
    input  wire logic [KEY_WIDTH-1:0]      shift_word,
    input  wire logic [CFG_WIDTH-1:0]      period_min,
    input  wire logic [CFG_WIDTH-1:0]      period_max,
    input  wire logic [CFG_WIDTH-1:0]      unlock_key,
    output pwmdec_flags_t                  flags,
    output logic                           edge_phase_next,
    output logic [INTERVAL_WIDTH-1:0]      prior_interval_next,
    output logic [KEY_WIDTH-1:0]           shift_word_next,
    output logic [CODE_WIDTH-1:0]          code_word
);

    // The cycle sum keeps its carry and is compared at a width that also holds the window limits.
    localparam int CMPW = (INTERVAL_WIDTH + 1 > CFG_WIDTH) ? INTERVAL_WIDTH + 1 : CFG_WIDTH;
    // Five times an interval needs three more bits.
    localparam int RW   = INTERVAL_WIDTH + 3;
    // The key compare runs at the wider of the shift word and the key register.
    localparam int WW   = (KEY_WIDTH > CFG_WIDTH) ? KEY_WIDTH : CFG_WIDTH;

    logic [CMPW-1:0]      cycle_sum;
    logic                 window_ok;
    logic [RW-1:0]        cur_ext;
    logic [RW-1:0]        prior_ext;
    logic                 high_longer;
    logic                 ratio_ok;
    logic [KEY_WIDTH-1:0] shifted_word;
    logic [WW-1:0]        word_ext;
    logic                 key_hit;

    // Cycle length and window check.
    assign cycle_sum = CMPW'(cur_interval) + CMPW'(prior_interval);
    assign window_ok = (cycle_sum <= CMPW'(period_max)) && (cycle_sum >= CMPW'(period_min));

    // Ratio check. The stored high time against the low time, or the mirror case.
    assign cur_ext     = RW'(cur_interval);
    assign prior_ext   = RW'(prior_interval);
    assign high_longer = prior_interval > cur_interval;

    always_comb begin
        if (high_longer) begin
            ratio_ok = (prior_ext > cur_ext * RW'(RATIO_LOW)) &&
                       (prior_ext < cur_ext * RW'(RATIO_HIGH));
        end else begin
            ratio_ok = (prior_ext * RW'(RATIO_LOW) < cur_ext) &&
                       (prior_ext * RW'(RATIO_HIGH) > cur_ext);
        end
    end

    // Shift word with the decoded bit appended, and the key compare.
    assign shifted_word = {shift_word[KEY_WIDTH-2:0], high_longer};
    assign word_ext     = WW'(shifted_word);
    assign key_hit      = word_ext == WW'(unlock_key);

    // Decision and next state.
    always_comb begin
        flags               = '0;
        edge_phase_next     = 1'b0;
        prior_interval_next = cur_interval;
        shift_word_next     = shift_word;
        if (!edge_phase) begin
            flags.was_rising = 1'b1;
            edge_phase_next  = 1'b1;
            if (prior_interval != '0) begin
                if (!window_ok || !ratio_ok) begin
                    flags.pulse_error   = 1'b1;
                    prior_interval_next = '0;
                end else begin
                    flags.bit_valid = 1'b1;
                    flags.bit_value = high_longer;
                    shift_word_next = shifted_word;
                    if (key_hit) begin
                        // A key match returns all state to its reset value.
                        flags.key_match     = 1'b1;
                        edge_phase_next     = 1'b0;
                        prior_interval_next = '0;
                        shift_word_next     = '0;
                    end
                end
            end
        end
    end

    // The reported word is read before any clear on a key match.
    always_comb begin
        if (flags.bit_valid) begin
            code_word = word_ext[CODE_WIDTH-1:0];
        end else begin
            code_word = CODE_WIDTH'(WW'(shift_word));
        end
    end

endmodule : pwmdec_eval

`default_nettype wire

@@ rtl/core/pwm_duty_bit_decoder_top.sv @@
// Pulse-width duty-cycle bit decoder: an input register, one evaluation pass, a result register.
// A result item passes through the input register and then into the result register; one item a cycle is taken
// while the result channel is not stalled. The state update is computed combinationally in pwmdec_eval.
// Synchronous active-low reset clears the state and both valid flags and reloads the registers.
// Depends on pwmdec_pkg and pwmdec_eval.
`default_nettype none

module pwm_duty_bit_decoder_top
    import pwmdec_pkg::*;
#(
    parameter int INTERVAL_WIDTH = 16,
    parameter int KEY_WIDTH      = 16
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write port
    input  wire logic                      cfg_wr_en,
    input  wire logic [1:0]                cfg_wr_index,
    input  wire logic [CFG_WIDTH-1:0]      cfg_wr_data,
    // Input channel
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [INTERVAL_WIDTH-1:0] s_edge_interval,
    // Result channel
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_was_rising,
    output logic                           m_bit_valid,
    output logic                           m_bit_value,
    output logic                           m_pulse_error,
    output logic                           m_key_match,
    output logic [CODE_WIDTH-1:0]          m_code_word
);

    // Register masks that follow the interval and key widths.
    localparam logic [CFG_WIDTH-1:0] IV_MASK =
        CFG_WIDTH'((65'd1 << INTERVAL_WIDTH) - 65'd1);
    localparam logic [CFG_WIDTH-1:0] KEY_MASK =
        CFG_WIDTH'((65'd1 << KEY_WIDTH) - 65'd1);

    logic [CFG_WIDTH-1:0]      period_min_reg;
    logic [CFG_WIDTH-1:0]      period_max_reg;
    logic [CFG_WIDTH-1:0]      unlock_key_reg;

    logic                      s1_valid_reg;
    logic [INTERVAL_WIDTH-1:0] s1_interval_reg;

    logic                      edge_phase_reg;
    logic                      edge_phase_next;
    logic [INTERVAL_WIDTH-1:0] prior_interval_reg;
    logic [INTERVAL_WIDTH-1:0] prior_interval_next;
    logic [KEY_WIDTH-1:0]      shift_word_reg;
    logic [KEY_WIDTH-1:0]      shift_word_next;

    logic                      m_valid_reg;
    pwmdec_flags_t             flags_reg;
    pwmdec_flags_t             flags_next;
    logic [CODE_WIDTH-1:0]     code_word_reg;
    logic [CODE_WIDTH-1:0]     code_word_next;

    logic                      s1_advance;

    // The input stage moves on when the result register is empty or being emptied.
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;

    // Configuration registers. Writes beyond the register list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_min_reg <= PERIOD_MIN_RESET & IV_MASK;
            period_max_reg <= PERIOD_MAX_RESET & IV_MASK;
            unlock_key_reg <= UNLOCK_KEY_RESET & KEY_MASK;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_PERIOD_MIN: period_min_reg <= cfg_wr_data & IV_MASK;
                REG_PERIOD_MAX: period_max_reg <= cfg_wr_data & IV_MASK;
                REG_UNLOCK_KEY: unlock_key_reg <= cfg_wr_data & KEY_MASK;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_interval_reg <= s_edge_interval;
        end
    end

    // Evaluation of the registered item against the decoder state.
    pwmdec_eval #(
        .INTERVAL_WIDTH(INTERVAL_WIDTH),
        .KEY_WIDTH     (KEY_WIDTH)
    ) u_eval (
        .cur_interval       (s1_interval_reg),
        .edge_phase         (edge_phase_reg),
        .prior_interval     (prior_interval_reg),
        .shift_word         (shift_word_reg),
        .period_min         (period_min_reg),
        .period_max         (period_max_reg),
        .unlock_key         (unlock_key_reg),
        .flags              (flags_next),
        .edge_phase_next    (edge_phase_next),
        .prior_interval_next(prior_interval_next),
        .shift_word_next    (shift_word_next),
        .code_word          (code_word_next)
    );

    // Decoder state, updated as each item passes into the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_phase_reg     <= 1'b0;
            prior_interval_reg <= '0;
            shift_word_reg     <= '0;
        end else if (s1_advance) begin
            edge_phase_reg     <= edge_phase_next;
            prior_interval_reg <= prior_interval_next;
            shift_word_reg     <= shift_word_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            flags_reg     <= flags_next;
            code_word_reg <= code_word_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_was_rising  = flags_reg.was_rising;
    assign m_bit_valid   = flags_reg.bit_valid;
    assign m_bit_value   = flags_reg.bit_value;
    assign m_pulse_error = flags_reg.pulse_error;
    assign m_key_match   = flags_reg.key_match;
    assign m_code_word   = code_word_reg;

    // A key match leaves the decoder in its reset state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance && flags_next.key_match |=>
            !edge_phase_reg && (prior_interval_reg == '0) && (shift_word_reg == '0))
        else $error("decoder state not cleared after key match");

    // Every item leaving the input stage lands in the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_advance |=> m_valid_reg)
        else $error("result register empty after an item advanced");

    // A decoded bit only comes from a rising edge without an error.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bit_valid |-> m_was_rising && !m_pulse_error)
        else $error("bit reported with falling edge or error");

endmodule : pwm_duty_bit_decoder_top

`default_nettype wire
